>>> src/wcc_pkg.sv
// Package for the warp coalescing counter: sizes, shared types and the
// saturating byte-total helper. No dependencies.
package wcc_pkg;

    // Chunk and line geometry
    localparam int CHUNK_SIZE = 32;
    localparam int LINE_BYTES = 32;
    localparam int ELEM_BYTES = 8;
    localparam int LINE_SHIFT = $clog2(LINE_BYTES / ELEM_BYTES);
    localparam int BYTE_SHIFT = $clog2(LINE_BYTES);

    // Field widths
    localparam int IDX_W  = 63;
    localparam int LINE_W = IDX_W - LINE_SHIFT;
    localparam int CNT_W  = 6;
    localparam int SLOT_W = $clog2(CHUNK_SIZE);
    localparam int POS_W  = 12;
    localparam int ROW_W  = 13;
    localparam int TOT_W  = 63;

    // Row length limits
    localparam logic [ROW_W-1:0] ROW_MIN   = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_MAX   = ROW_W'(4096);
    localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(32);
    localparam logic [CNT_W-1:0] CHUNK_CNT = CNT_W'(CHUNK_SIZE);

    // Control word from the counter to the line store
    typedef struct packed {
        logic             wr_en;
        logic [CNT_W-1:0] used;
    } t_cam_ctrl;

    // Add count * LINE_BYTES to a running total, clamping at the top
    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] total,
                                                 input logic [CNT_W-1:0] count);
        logic [TOT_W:0] ext;
        logic [TOT_W:0] sum;
        ext = (TOT_W+1)'(count) << BYTE_SHIFT;
        sum = {1'b0, total} + ext;
        return sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
    endfunction

endpackage

>>> src/warp_coalescing_counter.sv
// Warp coalescing counter: top level with the word register, chunk counters
// and result register. Depends on wcc_pkg and wcc_line_cam.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one sample index per
//   word. Each index maps to a 32-byte cache line. Words are grouped into
//   rows of row_length indices and each row into chunks of up to 32.
//   Output channel (o_out_valid / i_out_ready) carries one word per chunk:
//   fetched and saved line counts, saturating byte totals and row_done.
//   Config channel (i_cfg_valid / o_cfg_ready) writes row_length; always
//   ready, to be written only while the block is idle.
//   Order: an index is registered on acceptance and processed from the
//   input register; a chunk result is loaded into the result register at
//   the edge that processes its last index.
//   Throughput: one index per cycle unless a chunk result stalls, set by
//   the combinational compare of a new line against all occupied entries.
//   Reset: counters, totals and both valids clear; row_length returns to 32.
//   The line store needs no clearing.
//   Stall: a waiting result holds; indices that end no chunk still flow,
//   and an index that ends a chunk waits in the input register.
module warp_coalescing_counter
    import wcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [ROW_W-1:0] i_cfg_row_length,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [IDX_W-1:0] i_sample_index,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [CNT_W-1:0] o_chunk_fetched_lines,
    output logic [CNT_W-1:0] o_chunk_saved_lines,
    output logic [TOT_W-1:0] o_fetched_bytes_total,
    output logic [TOT_W-1:0] o_saved_bytes_total,
    output logic             o_row_done
);

    logic             r_row_length;
    logic [ROW_W-1:0] r_row_len;
    logic             r_in_valid;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_chunk_fill;
    logic [CNT_W-1:0] r_chunk_fetched;
    logic [POS_W-1:0] r_row_pos;
    logic [TOT_W-1:0] r_fetched_bytes;
    logic [TOT_W-1:0] r_saved_bytes;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_fetched;
    logic [CNT_W-1:0] r_out_saved;
    logic             r_out_row_done;

    logic [CNT_W-1:0] n_chunk_fill;
    logic [CNT_W-1:0] n_chunk_fetched;
    logic [CNT_W-1:0] n_saved;
    logic [ROW_W-1:0] n_pos;
    logic [ROW_W-1:0] eff_len;
    logic [LINE_W-1:0] line;
    logic             hit;
    logic             is_new;
    logic             row_end;
    logic             chunk_end;
    logic             out_free;
    logic             proc_fire;
    t_cam_ctrl        cam_ctrl;

    // Config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= 1'b0;
            r_row_len    <= ROW_RESET;
        end else if (i_cfg_valid) begin
            r_row_length <= 1'b1;
            r_row_len    <= i_cfg_row_length;
        end
    end

    // Clamp the row length into its legal range
    always_comb begin
        if (r_row_len < ROW_MIN) begin
            eff_len = ROW_MIN;
        end else if (r_row_len > ROW_MAX) begin
            eff_len = ROW_MAX;
        end else begin
            eff_len = r_row_len;
        end
    end

    // Line number of the registered index
    assign line = r_idx[IDX_W-1:LINE_SHIFT];

    assign cam_ctrl.used  = r_chunk_fetched;
    assign cam_ctrl.wr_en = proc_fire && is_new;

    wcc_line_cam u_cam (
        .i_clk  (i_clk),
        .i_line (line),
        .i_ctrl (cam_ctrl),
        .o_hit  (hit)
    );

    // Chunk bookkeeping for the word in the input register
    always_comb begin
        is_new          = !hit && (r_chunk_fetched < CHUNK_CNT);
        n_chunk_fetched = r_chunk_fetched + CNT_W'(is_new);
        n_chunk_fill    = r_chunk_fill + CNT_W'(1);
        n_saved         = n_chunk_fill - n_chunk_fetched;
        n_pos           = {1'b0, r_row_pos} + ROW_W'(1);
        row_end         = (n_pos >= eff_len) || r_row_length == 1'b0 && n_pos >= eff_len;
        chunk_end       = (n_chunk_fill >= CHUNK_CNT) || row_end;
    end

    // Handshake: advance unless a chunk result cannot be placed
    assign out_free   = !r_out_valid || i_out_ready;
    assign proc_fire  = r_in_valid && (!chunk_end || out_free);
    assign o_in_ready = !r_in_valid || proc_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_idx <= i_sample_index;
        end
    end

    // Chunk counters, row position and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_fill    <= '0;
            r_chunk_fetched <= '0;
            r_row_pos       <= '0;
            r_fetched_bytes <= '0;
            r_saved_bytes   <= '0;
        end else if (proc_fire) begin
            if (chunk_end) begin
                r_chunk_fill    <= '0;
                r_chunk_fetched <= '0;
                r_row_pos       <= row_end ? '0 : n_pos[POS_W-1:0];
                r_fetched_bytes <= sat_add(r_fetched_bytes, n_chunk_fetched);
                r_saved_bytes   <= sat_add(r_saved_bytes, n_saved);
            end else begin
                r_chunk_fill    <= n_chunk_fill;
                r_chunk_fetched <= n_chunk_fetched;
                r_row_pos       <= n_pos[POS_W-1:0];
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && chunk_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && chunk_end) begin
            r_out_fetched  <= n_chunk_fetched;
            r_out_saved    <= n_saved;
            r_out_row_done <= row_end;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_chunk_fetched_lines = r_out_fetched;
    assign o_chunk_saved_lines   = r_out_saved;
    assign o_fetched_bytes_total = r_fetched_bytes;
    assign o_saved_bytes_total   = r_saved_bytes;
    assign o_row_done            = r_out_row_done;

endmodule

>>> src/wcc_line_cam.sv
// Line store of the current chunk with a parallel compare on every entry.
// Depends on wcc_pkg.
module wcc_line_cam
    import wcc_pkg::*;
(
    input  logic              i_clk,
    input  logic [LINE_W-1:0] i_line,
    input  t_cam_ctrl         i_ctrl,
    output logic              o_hit
);

    logic [LINE_W-1:0] r_store [CHUNK_SIZE];

    // Compare the line against every occupied entry
    always_comb begin
        o_hit = 1'b0;
        for (int i = 0; i < CHUNK_SIZE; i++) begin
            if ((CNT_W'(i) < i_ctrl.used) && (r_store[i] == i_line)) begin
                o_hit = 1'b1;
            end
        end
    end

    // Append a new line at the next free entry
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_store[i_ctrl.used[SLOT_W-1:0]] <= i_line;
        end
    end

endmodule

>>> src/wcc_checker.sv
// Port-level checks for the warp coalescing counter, bound to the top level.
// Depends on wcc_pkg.
module wcc_checker
    import wcc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [CNT_W-1:0] o_chunk_fetched_lines,
    input logic [CNT_W-1:0] o_chunk_saved_lines,
    input logic [TOT_W-1:0] o_fetched_bytes_total
);

    // Reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // Running total is frozen while a result waits
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_fetched_bytes_total))
        else $error("byte total moved under a stalled result");

    // Every chunk has at least one fetch and at most a chunk of accesses
    a_chunk_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_chunk_fetched_lines != '0) &&
            ((CNT_W+1)'(o_chunk_fetched_lines) + (CNT_W+1)'(o_chunk_saved_lines)
                <= (CNT_W+1)'(CHUNK_SIZE)))
        else $error("chunk counts out of range");

endmodule

bind warp_coalescing_counter wcc_checker u_wcc_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_chunk_fetched_lines (o_chunk_fetched_lines),
    .o_chunk_saved_lines   (o_chunk_saved_lines),
    .o_fetched_bytes_total (o_fetched_bytes_total)
);
